// ----- rtl/pmtp_pkg.sv -----
// ----------------------------------------------------------------------------
// pmtp_pkg
// Shared types and constants of the PMT section descriptor parser.
// ----------------------------------------------------------------------------
package pmtp_pkg;

    localparam int HEADER_BYTES    = 12;
    localparam int CRC_BYTES       = 4;
    localparam int ES_HEAD_BYTES   = 5;
    localparam int SPEC_BYTES      = 4;
    localparam int SUB_ENTRY_BYTES = 8;
    localparam int SUB_ENTRY_CAP   = 8;

    localparam logic [2:0] KIND_PROGRAM  = 3'd0;
    localparam logic [2:0] KIND_STREAM   = 3'd1;
    localparam logic [2:0] KIND_SPEC     = 3'd2;
    localparam logic [2:0] KIND_SUBTITLE = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_EARLY = 2'd2;

    localparam logic       CFG_SPECIFIER_TAG = 1'b0;
    localparam logic       CFG_SUBTITLE_TAG  = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } pmtp_in_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic        stream_level;
        logic [7:0]  stream_number;
        logic [31:0] word_value;
        logic [15:0] pid_or_page;
        logic [15:0] ancillary_page;
        logic [7:0]  subtitle_kind;
        logic [1:0]  end_status;
        logic        run_end;
    } pmtp_out_t;

    // up to two results of one byte, handed from the parser to the queue
    typedef struct packed {
        logic      first_valid;
        pmtp_out_t first;
        logic      second_valid;
        pmtp_out_t second;
    } pmtp_pair_t;

endpackage

// ----- rtl/pmtp_front.sv -----
// ----------------------------------------------------------------------------
// pmtp_front
// Byte parser: walks the section and classifies each byte into records.
// ----------------------------------------------------------------------------
module pmtp_front
    import pmtp_pkg::*;
#(
    parameter int MAX_SPECIFIERS     = 16,
    parameter int MAX_SUBTITLE_DESCS = 8,
    parameter int MAX_SECTION_BYTES  = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  pmtp_in_t   in_item,
    input  logic [7:0] specifier_tag,
    input  logic [7:0] subtitle_tag,
    output pmtp_pair_t pair
);

    localparam int PW = ((MAX_SECTION_BYTES > 4095) ? $clog2(MAX_SECTION_BYTES + 1) : 12) + 1;
    localparam int SCW = $clog2(MAX_SPECIFIERS + 1);
    localparam int TCW = $clog2(MAX_SUBTITLE_DESCS + 1);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TAG     = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_BODY    = 3'd3;
    localparam logic [2:0] PH_STOPPED = 3'd4;
    localparam logic [2:0] PH_ES_HEAD = 3'd5;
    localparam logic [2:0] PH_TAIL    = 3'd6;
    localparam logic [2:0] PH_ERROR   = 3'd7;

    localparam logic [1:0] MD_SKIP = 2'd0;
    localparam logic [1:0] MD_SPEC = 2'd1;
    localparam logic [1:0] MD_SUB  = 2'd2;

    logic [PW-1:0]  pos_reg, pos_next;
    logic [PW-1:0]  pend_reg, pend_next;
    logic [PW-1:0]  lend_reg, lend_next;
    logic [PW-1:0]  dend_reg, dend_next;
    logic [2:0]     phase_reg, phase_next;
    logic [1:0]     mode_reg, mode_next;
    logic [3:0]     left_reg, left_next;
    logic [SCW-1:0] spc_reg, spc_next;
    logic [TCW-1:0] stc_reg, stc_next;
    logic [63:0]    shift_reg, shift_next;
    logic [7:0]     cur_reg, cur_next;
    logic [3:0]     piece_reg, piece_next;
    logic           level_reg, level_next;

    logic [7:0]    b;
    logic [PW-1:0] bx, p1, total, pil, eil, lim;
    logic [63:0]   sh;
    logic [2:0]    ph;
    logic [3:0]    pc;
    pmtp_out_t     r0, r1;
    logic          v0, v1;

    always_comb
    begin
        b = in_item.data_byte;
        bx = PW'(b);
        p1 = pos_reg + PW'(1);
        pos_next = pos_reg; pend_next = pend_reg; lend_next = lend_reg;
        dend_next = dend_reg; phase_next = phase_reg; mode_next = mode_reg;
        left_next = left_reg; spc_next = spc_reg; stc_next = stc_reg;
        shift_next = shift_reg; cur_next = cur_reg; piece_next = piece_reg;
        level_next = level_reg;
        r0 = '0; r1 = '0; v0 = 1'b0; v1 = 1'b0;
        total = '0; pil = '0; eil = '0; lim = '0; sh = '0; ph = phase_reg; pc = piece_reg;

        if (phase_reg == PH_HEADER)
        begin
            sh = {shift_reg[55:0], b};
            shift_next = sh;
            if (pos_reg == PW'(2))
            begin
                total = PW'({sh[11:8], sh[7:0]}) + PW'(3);
                if (total < PW'(HEADER_BYTES + CRC_BYTES)
                    || total > PW'(MAX_SECTION_BYTES))
                    phase_next = PH_ERROR;
                else
                    pend_next = total - PW'(CRC_BYTES);
            end
            else if (pos_reg == PW'(9))
            begin
                v0 = 1'b1;
                r0.record_kind = KIND_PROGRAM;
                r0.word_value = {16'd0, sh[55:40]};
                r0.pid_or_page = {3'd0, sh[12:8], sh[7:0]};
            end
            else if (pos_reg == PW'(HEADER_BYTES - 1))
            begin
                pil = PW'({sh[11:8], sh[7:0]}) + PW'(HEADER_BYTES);
                lend_next = (pil > pend_reg) ? pend_reg : pil;
                level_next = 1'b0;
                phase_next = PH_TAG;
                mode_next = MD_SKIP; spc_next = '0; stc_next = '0; left_next = '0;
            end
        end
        else if (phase_reg != PH_TAIL && phase_reg != PH_ERROR)
        begin
            if (phase_reg >= PH_TAG && phase_reg <= PH_STOPPED && pos_reg >= lend_reg)
            begin
                if (level_reg && cur_reg != 8'd255)
                    cur_next = cur_reg + 8'd1;
                ph = PH_ES_HEAD;
                pc = '0;
            end
            if (ph == PH_ES_HEAD && pc == '0
                && (pos_reg >= pend_reg || pend_reg - pos_reg < PW'(ES_HEAD_BYTES)))
                ph = PH_TAIL;
            phase_next = ph;
            piece_next = pc;

            if (ph == PH_ES_HEAD)
            begin
                sh = (pc == '0) ? {56'd0, b} : {shift_reg[55:0], b};
                shift_next = sh;
                piece_next = pc + 4'd1;
                if (pc + 4'd1 >= 4'(ES_HEAD_BYTES))
                begin
                    eil = PW'({sh[11:8], sh[7:0]});
                    piece_next = '0;
                    lim = p1 + eil;
                    if (lim > pend_reg)
                        phase_next = PH_TAIL;
                    else
                    begin
                        v0 = 1'b1;
                        r0.record_kind = KIND_STREAM;
                        r0.stream_level = 1'b1;
                        r0.stream_number = cur_next;
                        r0.word_value = {24'd0, sh[39:32]};
                        r0.pid_or_page = {3'd0, sh[28:24], sh[23:16]};
                        lend_next = lim; level_next = 1'b1; phase_next = PH_TAG;
                        mode_next = MD_SKIP; spc_next = '0; stc_next = '0; left_next = '0;
                    end
                end
            end
            else if (ph == PH_TAG)
            begin
                if (pos_reg + PW'(2) > lend_reg)
                    phase_next = PH_STOPPED;
                else
                begin
                    shift_next = {56'd0, b};
                    phase_next = PH_LEN;
                end
            end
            else if (ph == PH_LEN)
            begin
                lim = p1 + bx;
                if (lim > lend_reg)
                    phase_next = PH_STOPPED;
                else
                begin
                    dend_next = lim;
                    mode_next = MD_SKIP;
                    if (shift_reg[7:0] == specifier_tag)
                    begin
                        if (spc_reg < SCW'(MAX_SPECIFIERS) && b >= 8'(SPEC_BYTES))
                        begin
                            spc_next = spc_reg + SCW'(1);
                            mode_next = MD_SPEC;
                        end
                    end
                    else if (shift_reg[7:0] == subtitle_tag)
                    begin
                        if (stc_reg < TCW'(MAX_SUBTITLE_DESCS) && b >= 8'(SUB_ENTRY_BYTES))
                        begin
                            stc_next = stc_reg + TCW'(1);
                            mode_next = MD_SUB;
                            left_next = (b[7:3] > 5'(SUB_ENTRY_CAP)) ? 4'(SUB_ENTRY_CAP)
                                                                     : b[6:3];
                        end
                    end
                    piece_next = '0;
                    shift_next = '0;
                    phase_next = (b == 8'd0) ? PH_TAG : PH_BODY;
                end
            end
            else if (ph == PH_BODY)
            begin
                sh = {shift_reg[55:0], b};
                if (mode_reg == MD_SPEC)
                begin
                    shift_next = sh;
                    piece_next = pc + 4'd1;
                    if (pc + 4'd1 >= 4'(SPEC_BYTES))
                    begin
                        v0 = 1'b1;
                        r0.record_kind = KIND_SPEC;
                        r0.stream_level = level_reg;
                        r0.stream_number = level_reg ? cur_reg : 8'd0;
                        r0.word_value = sh[31:0];
                        mode_next = MD_SKIP;
                    end
                end
                else if (mode_reg == MD_SUB)
                begin
                    shift_next = sh;
                    piece_next = pc + 4'd1;
                    if (pc + 4'd1 >= 4'(SUB_ENTRY_BYTES))
                    begin
                        v0 = 1'b1;
                        r0.record_kind = KIND_SUBTITLE;
                        r0.stream_level = level_reg;
                        r0.stream_number = level_reg ? cur_reg : 8'd0;
                        r0.word_value = {8'd0, sh[63:40]};
                        r0.subtitle_kind = sh[39:32];
                        r0.pid_or_page = sh[31:16];
                        r0.ancillary_page = sh[15:0];
                        piece_next = '0;
                        shift_next = '0;
                        left_next = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
                        if (left_reg <= 4'd1)
                            mode_next = MD_SKIP;
                    end
                end
                if (p1 >= dend_reg)
                begin
                    phase_next = PH_TAG;
                    mode_next = MD_SKIP;
                end
            end
        end

        if (pos_reg < PW'(MAX_SECTION_BYTES))
            pos_next = p1;

        if (in_item.final_byte)
        begin
            r1.record_kind = KIND_END;
            if (phase_next == PH_ERROR)
                r1.end_status = STATUS_SHORT;
            else if (phase_next == PH_HEADER)
                r1.end_status = STATUS_EARLY;
            else if (p1 < pend_reg + PW'(CRC_BYTES))
                r1.end_status = STATUS_EARLY;
            else
                r1.end_status = STATUS_OK;
            r1.run_end = 1'b1;
            v1 = 1'b1;
            pos_next = '0; pend_next = '0; lend_next = '0; dend_next = '0;
            phase_next = PH_HEADER; mode_next = MD_SKIP; left_next = '0;
            spc_next = '0; stc_next = '0; shift_next = '0; cur_next = '0;
            piece_next = '0; level_next = 1'b0;
        end
        else
            r0.run_end = 1'b1;

        pair.first_valid = v0;
        pair.first = r0;
        pair.second_valid = v1;
        pair.second = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; pend_reg <= '0; lend_reg <= '0; dend_reg <= '0;
            phase_reg <= PH_HEADER; mode_reg <= MD_SKIP; left_reg <= '0;
            spc_reg <= '0; stc_reg <= '0; shift_reg <= '0; cur_reg <= '0;
            piece_reg <= '0; level_reg <= 1'b0;
        end
        else if (step)
        begin
            pos_reg <= pos_next; pend_reg <= pend_next; lend_reg <= lend_next;
            dend_reg <= dend_next; phase_reg <= phase_next; mode_reg <= mode_next;
            left_reg <= left_next; spc_reg <= spc_next; stc_reg <= stc_next;
            shift_reg <= shift_next; cur_reg <= cur_next; piece_reg <= piece_next;
            level_reg <= level_next;
        end
    end

endmodule

// ----- rtl/pmtp_back.sv -----
// ----------------------------------------------------------------------------
// pmtp_back
// Record queue: holds parsed records and hands them out one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module pmtp_back
    import pmtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pmtp_pair_t pair,
    output logic       room,
    output logic       out_valid,
    output pmtp_out_t  out_data,
    input  logic       out_stall
);

    localparam int DEPTH = 4;

    pmtp_out_t  mem_reg [DEPTH];
    logic [1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] nin;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = mem_reg[rp_reg];
    assign pop  = out_valid && !out_stall;
    assign room = (cnt_reg <= 3'd2);
    assign nin  = push ? (2'(pair.first_valid) + 2'(pair.second_valid)) : 2'd0;

    always_comb
    begin
        rp_next  = rp_reg + 2'(pop);
        wp_next  = wp_reg + nin;
        cnt_next = cnt_reg + 3'(nin) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push && pair.first_valid)
            mem_reg[wp_reg] <= pair.first;
        if (push && pair.second_valid)
            mem_reg[wp_reg + 2'(pair.first_valid)] <= pair.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/pmt_section_descriptor_parser_core.sv -----
// ----------------------------------------------------------------------------
// pmt_section_descriptor_parser_core
// PMT section parser reporting program, stream, specifier and subtitle records.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one section byte per
// transaction with a final flag. Output channel out_valid/out_stall/out_data
// carries one record per transaction; a byte yields up to two records, the
// last one of a byte marked with run_end.
// Throughput: one byte per cycle while the output drains one record per
// cycle; the parser takes a byte whenever the four-entry record queue has
// two free slots. Each record is registered in the queue before it is output.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the two descriptor
// tags and take effect on the next byte.
// Reset clears parser state and the queue and restores tags 95 and 89.
// A stalled receiver backs up the queue; in_stall rises at three records.
// ----------------------------------------------------------------------------
module pmt_section_descriptor_parser_core
    import pmtp_pkg::*;
#(
    parameter int MAX_SPECIFIERS     = 16,
    parameter int MAX_SUBTITLE_DESCS = 8,
    parameter int MAX_SECTION_BYTES  = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pmtp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output pmtp_out_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] spec_tag_reg, sub_tag_reg;
    logic       room, step;
    pmtp_pair_t pair;

    assign in_stall = !room;
    assign step = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spec_tag_reg <= 8'd95;
            sub_tag_reg  <= 8'd89;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SPECIFIER_TAG)
                spec_tag_reg <= cfg_data;
            else
                sub_tag_reg <= cfg_data;
        end
    end

    pmtp_front #(
        .MAX_SPECIFIERS     (MAX_SPECIFIERS),
        .MAX_SUBTITLE_DESCS (MAX_SUBTITLE_DESCS),
        .MAX_SECTION_BYTES  (MAX_SECTION_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .in_item       (in_data),
        .specifier_tag (spec_tag_reg),
        .subtitle_tag  (sub_tag_reg),
        .pair          (pair)
    );

    pmtp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .pair      (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall)
    );

endmodule

// ----- tb/sv/pmt_section_descriptor_parser_core_test.sv -----
// ----------------------------------------------------------------------------
// pmt_section_descriptor_parser_core_test
// Self-checking bench for the PMT section descriptor parser. Random PMT
// sections are built with specifier and subtitling descriptors, some of them
// truncated, corrupted or given bad lengths. The bytes are fed in bursts
// against a stalling receiver, and every record is checked against a local
// byte-level parser model. The tag registers are changed between phases.
// ----------------------------------------------------------------------------
module pmt_section_descriptor_parser_core_test;
    import pmtp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SPECS     = 16;
    localparam int MAX_SUB_DESCS = 8;
    localparam int MAX_BYTES     = 1024;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum int {SEC_HEADER, SEC_TAG, SEC_LEN, SEC_BODY, SEC_STOPPED,
                      SEC_ES_HEAD, SEC_TAIL, SEC_ERROR} sec_phase_t;
    typedef enum int {DESC_SKIP, DESC_SPEC, DESC_SUB} desc_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pmtp_in_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    pmtp_out_t  out_data;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_SPECIFIER_TAG;
    logic [7:0] cfg_data = '0;

    pmt_section_descriptor_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    pmtp_in_t   byte_feed[$];
    pmtp_out_t  expected_records[$];
    int         errors = 0;
    int         bytes_sent = 0;
    int         records_seen = 0;
    int         sections_built = 0;
    int         cycles = 0;
    int         hold_request = 0;
    logic [7:0] spec_tag = 8'd95;
    logic [7:0] sub_tag = 8'd89;

    int unsigned pos, sec_end, lp_end, d_end, ents_left, spec_cnt, sub_cnt, piece;
    sec_phase_t  phase;
    desc_mode_t  d_mode;
    logic [63:0] acc;
    logic [7:0]  stream_idx;
    logic        in_es_loop;

    function automatic void clear_parser();
        pos = 0; sec_end = 0; phase = SEC_HEADER; lp_end = 0; d_end = 0;
        d_mode = DESC_SKIP; ents_left = 0; spec_cnt = 0; sub_cnt = 0;
        acc = '0; stream_idx = '0; piece = 0; in_es_loop = 1'b0;
    endfunction

    function automatic pmtp_out_t make_record(logic [2:0] kind, logic lvl, logic [7:0] num,
                                              logic [31:0] word, logic [15:0] pid,
                                              logic [15:0] anc, logic [7:0] sk,
                                              logic [1:0] st);
        pmtp_out_t r;
        r.record_kind = kind; r.stream_level = lvl; r.stream_number = num;
        r.word_value = word; r.pid_or_page = pid; r.ancillary_page = anc;
        r.subtitle_kind = sk; r.end_status = st; r.run_end = 1'b0;
        return r;
    endfunction

    function automatic void open_loop(int unsigned e, logic lvl);
        lp_end = e; in_es_loop = lvl; phase = SEC_TAG; d_mode = DESC_SKIP;
        spec_cnt = 0; sub_cnt = 0; ents_left = 0;
    endfunction

    function automatic void parse_byte(pmtp_in_t it);
        pmtp_out_t   recs[$];
        logic [7:0]  b;
        int unsigned p, total, pil, e, eil, len;
        logic [7:0]  tag, num;
        logic [1:0]  st;
        b = it.data_byte;
        p = pos;
        if (phase == SEC_HEADER) begin
            acc = {acc[55:0], b};
            if (p == 2) begin
                total = 32'({acc[11:8], acc[7:0]}) + 3;
                if (total < HEADER_BYTES + CRC_BYTES || total > MAX_BYTES)
                    phase = SEC_ERROR;
                else
                    sec_end = total - CRC_BYTES;
            end else if (p == 9) begin
                recs.push_back(make_record(KIND_PROGRAM, 1'b0, 8'd0, {16'd0, acc[55:40]},
                                           {3'd0, acc[12:8], acc[7:0]}, 16'd0, 8'd0,
                                           STATUS_OK));
            end else if (p == HEADER_BYTES - 1) begin
                pil = 32'({acc[11:8], acc[7:0]});
                e = HEADER_BYTES + pil;
                if (e > sec_end) e = sec_end;
                open_loop(e, 1'b0);
            end
        end else if (phase != SEC_TAIL && phase != SEC_ERROR) begin
            if (phase >= SEC_TAG && phase <= SEC_STOPPED && p >= lp_end) begin
                if (in_es_loop && stream_idx < 8'd255) stream_idx++;
                phase = SEC_ES_HEAD;
                piece = 0;
            end
            if (phase == SEC_ES_HEAD && piece == 0 &&
                (p >= sec_end || sec_end - p < ES_HEAD_BYTES))
                phase = SEC_TAIL;
            if (phase == SEC_ES_HEAD) begin
                acc = (piece == 0) ? {56'd0, b} : {acc[55:0], b};
                piece++;
                if (piece >= ES_HEAD_BYTES) begin
                    eil = 32'({acc[11:8], acc[7:0]});
                    piece = 0;
                    if (p + 1 + eil > sec_end) begin
                        phase = SEC_TAIL;
                    end else begin
                        recs.push_back(make_record(KIND_STREAM, 1'b1, stream_idx,
                                                   {24'd0, acc[39:32]},
                                                   {3'd0, acc[28:24], acc[23:16]},
                                                   16'd0, 8'd0, STATUS_OK));
                        open_loop(p + 1 + eil, 1'b1);
                    end
                end
            end else if (phase == SEC_TAG) begin
                if (p + 2 > lp_end) begin
                    phase = SEC_STOPPED;
                end else begin
                    acc = {56'd0, b};
                    phase = SEC_LEN;
                end
            end else if (phase == SEC_LEN) begin
                tag = acc[7:0];
                len = 32'(b);
                if (p + 1 + len > lp_end) begin
                    phase = SEC_STOPPED;
                end else begin
                    d_end = p + 1 + len;
                    d_mode = DESC_SKIP;
                    if (tag == spec_tag) begin
                        if (spec_cnt < MAX_SPECS && len >= SPEC_BYTES) begin
                            spec_cnt++;
                            d_mode = DESC_SPEC;
                        end
                    end else if (tag == sub_tag) begin
                        if (sub_cnt < MAX_SUB_DESCS && len >= SUB_ENTRY_BYTES) begin
                            sub_cnt++;
                            d_mode = DESC_SUB;
                            ents_left = len / SUB_ENTRY_BYTES;
                            if (ents_left > SUB_ENTRY_CAP) ents_left = SUB_ENTRY_CAP;
                        end
                    end
                    piece = 0;
                    acc = '0;
                    phase = (len == 0) ? SEC_TAG : SEC_BODY;
                end
            end else if (phase == SEC_BODY) begin
                num = in_es_loop ? stream_idx : 8'd0;
                if (d_mode == DESC_SPEC) begin
                    acc = {acc[55:0], b};
                    piece++;
                    if (piece >= SPEC_BYTES) begin
                        recs.push_back(make_record(KIND_SPEC, in_es_loop, num, acc[31:0],
                                                   16'd0, 16'd0, 8'd0, STATUS_OK));
                        d_mode = DESC_SKIP;
                    end
                end else if (d_mode == DESC_SUB) begin
                    acc = {acc[55:0], b};
                    piece++;
                    if (piece >= SUB_ENTRY_BYTES) begin
                        recs.push_back(make_record(KIND_SUBTITLE, in_es_loop, num,
                                                   {8'd0, acc[63:40]}, acc[31:16],
                                                   acc[15:0], acc[39:32], STATUS_OK));
                        piece = 0;
                        acc = '0;
                        if (ents_left > 0) ents_left--;
                        if (ents_left == 0) d_mode = DESC_SKIP;
                    end
                end
                if (p + 1 >= d_end) begin
                    phase = SEC_TAG;
                    d_mode = DESC_SKIP;
                end
            end
        end
        if (pos < MAX_BYTES) pos++;
        if (it.final_byte) begin
            if (phase == SEC_ERROR) st = STATUS_SHORT;
            else if (phase == SEC_HEADER) st = STATUS_EARLY;
            else if (p + 1 < sec_end + CRC_BYTES) st = STATUS_EARLY;
            else st = STATUS_OK;
            recs.push_back(make_record(KIND_END, 1'b0, 8'd0, 32'd0, 16'd0, 16'd0, 8'd0, st));
            clear_parser();
        end
        if (recs.size() > 0) recs[recs.size() - 1].run_end = 1'b1;
        foreach (recs[i]) expected_records.push_back(recs[i]);
    endfunction

    // ---- driver ----
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                parse_byte(in_data);
                bytes_sent++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_feed.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= byte_feed.pop_front();
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---- receiver stall ----
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 1) == 1);
            else if (stall_mode == 2)
                out_stall <= (cycles % 3 == 0);
            else
                out_stall <= 1'b0;
        end
    end

    // ---- monitor ----
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            records_seen++;
            if (expected_records.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected record %p", $realtime, out_data);
            end
            else if (out_data !== expected_records[0])
            begin
                errors++;
                $display("%0t: mismatch expected %p actual %p", $realtime,
                         expected_records[0], out_data);
                void'(expected_records.pop_front());
            end
            else
            begin
                void'(expected_records.pop_front());
            end
        end
    end

    // ---- stimulus ----
    task automatic add_descs(inout logic [7:0] q[$], input int count, input bit caps);
        int kind, len;
        logic [7:0] tag;
        for (int i = 0; i < count; i++)
        begin
            kind = caps ? (i % 2) : $urandom_range(0, 4);
            case (kind)
                0: begin tag = spec_tag; len = caps ? 4 : $urandom_range(4, 7); end
                1: begin tag = sub_tag;
                         len = caps ? 8 : 8 * $urandom_range(1, 3) + $urandom_range(0, 1) * 3;
                   end
                2: begin tag = spec_tag; len = $urandom_range(0, 3); end
                3: begin tag = sub_tag; len = $urandom_range(0, 7); end
                default: begin tag = 8'($urandom); len = $urandom_range(0, 6); end
            endcase
            q.push_back(tag);
            q.push_back(len[7:0]);
            for (int k = 0; k < len; k++) q.push_back(8'($urandom));
        end
    endtask

    task automatic make_section(input int mode);
        logic [7:0] sec[$];
        logic [7:0] loop_bytes[$];
        int slen, pil, eil, streams, last, bad;
        pmtp_in_t it;
        repeat (12) sec.push_back(8'($urandom));
        if (mode == 5)
        begin
            add_descs(loop_bytes, 36, 1'b1);
            add_descs(loop_bytes, 2, 1'b0);
            loop_bytes.push_back(sub_tag);
            loop_bytes.push_back(8'd80);
            repeat (80) loop_bytes.push_back(8'($urandom));
        end
        else
            add_descs(loop_bytes, $urandom_range(0, 4), 1'b0);
        pil = loop_bytes.size();
        sec[10] = {sec[10][7:4], pil[11:8]};
        sec[11] = pil[7:0];
        foreach (loop_bytes[i]) sec.push_back(loop_bytes[i]);
        streams = $urandom_range(0, 4);
        for (int s = 0; s < streams; s++)
        begin
            loop_bytes.delete();
            add_descs(loop_bytes, $urandom_range(0, 3), 1'b0);
            eil = loop_bytes.size();
            sec.push_back(8'($urandom));
            sec.push_back(8'($urandom));
            sec.push_back(8'($urandom));
            sec.push_back({4'($urandom), eil[11:8]});
            sec.push_back(eil[7:0]);
            foreach (loop_bytes[i]) sec.push_back(loop_bytes[i]);
        end
        repeat (4) sec.push_back(8'($urandom));
        slen = sec.size() - 3;
        sec[1] = {sec[1][7:4], slen[11:8]};
        sec[2] = slen[7:0];
        last = sec.size() - 1;
        case (mode)
            1: last = $urandom_range(0, sec.size() - 2);
            2: begin
                bad = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 12)
                                                  : $urandom_range(1022, 4095);
                sec[1] = {sec[1][7:4], bad[11:8]};
                sec[2] = bad[7:0];
                last = $urandom_range(2, sec.size() - 1);
            end
            3: repeat ($urandom_range(1, 3)) sec[$urandom_range(12, sec.size() - 1)] = 8'($urandom);
            4: begin
                repeat ($urandom_range(1, 6)) sec.push_back(8'($urandom));
                last = sec.size() - 1;
            end
            6: begin
                sec[10] = 8'($urandom);
                sec[11] = 8'($urandom);
            end
            default: ;
        endcase
        for (int i = 0; i <= last; i++)
        begin
            it.data_byte = sec[i];
            it.final_byte = (i == last);
            byte_feed.push_back(it);
        end
        sections_built++;
    endtask

    task automatic push_bytes(input logic [7:0] vals[$]);
        pmtp_in_t it;
        foreach (vals[i])
        begin
            it.data_byte = vals[i];
            it.final_byte = (i == vals.size() - 1);
            byte_feed.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (byte_feed.size() > 0 || in_valid || expected_records.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tags(input logic [7:0] st, input logic [7:0] ut);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SPECIFIER_TAG;
        cfg_data  <= st;
        @(posedge clk);
        cfg_index <= CFG_SUBTITLE_TAG;
        cfg_data  <= ut;
        @(posedge clk);
        cfg_we    <= 1'b0;
        spec_tag = st;
        sub_tag = ut;
    endtask

    initial
    begin
        logic [7:0] tag_sets[5][2];
        int r;
        tag_sets = '{'{8'd95, 8'd89}, '{8'd0, 8'd255}, '{8'd255, 8'd0},
                     '{8'd7, 8'd7}, '{8'h40, 8'h50}};
        clear_parser();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_bytes('{8'h02, 8'hB0, 8'h0D, 8'hFF, 8'hFF, 8'hC1, 8'h00, 8'h00,
                     8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44});
        push_bytes('{8'h02, 8'h00, 8'h05});
        push_bytes('{8'h02, 8'h00});
        make_section(0);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 5) write_tags(tag_sets[ph][0], tag_sets[ph][1]);
            else write_tags(8'($urandom), 8'($urandom));
            if (ph == 2) hold_request = 300;
            while (byte_feed.size() < 60)
            begin
                r = $urandom_range(0, 19);
                if (r == 12) make_section(1);
                else if (r == 13) make_section(2);
                else if (r == 14) make_section(3);
                else if (r == 15) make_section(4);
                else if (r == 16 && ph % 2 == 0) make_section(5);
                else if (r == 17) make_section(6);
                else make_section(0);
            end
            wait_idle();
        end

        $display("%0d sections, %0d bytes, %0d records checked over six tag settings",
                 sections_built, bytes_sent, records_seen);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/pmtp_pkg.sv
rtl/pmtp_front.sv
rtl/pmtp_back.sv
rtl/pmt_section_descriptor_parser_core.sv
tb/sv/pmt_section_descriptor_parser_core_test.sv
